/* src/lclp_pkg.sv */
// Shared widths, register indexes and reset values for the load-cell filter.
`default_nettype none

package lclp_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int TARED_W  = 25;
    localparam int GAIN_W   = 9;
    localparam int LEVEL_W  = 33;
    localparam int FRAC_W   = 8;

    // Default averaging window
    localparam int DEFAULT_WINDOW = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TARE = 1'd0;
    localparam t_cfg_idx CFG_GAIN = 1'd1;

    // Register reset values
    localparam logic signed [SAMPLE_W-1:0] TARE_RESET = '0;
    localparam logic [GAIN_W-1:0]          GAIN_RESET = 9'd64;

    // Limits of the smoothed level
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

endpackage

`default_nettype wire

/* src/lclp_avg_div.sv */
// Pipelined Q8 average: running sum * 256 / WINDOW, truncated toward zero.
`default_nettype none

module lclp_avg_div #(
    parameter int WINDOW = lclp_pkg::DEFAULT_WINDOW
) (
    input  wire                                                   i_clk,
    input  wire                                                   i_rst_n,
    input  wire                                                   i_in_valid,
    output logic                                                  o_in_ready,
    input  wire signed [lclp_pkg::TARED_W+$clog2(WINDOW)-1:0]     i_sum,
    input  wire                                                   i_full,
    output logic                                                  o_out_valid,
    input  wire                                                   i_out_ready,
    output logic signed [lclp_pkg::TARED_W+$clog2(WINDOW)+8:0]    o_avg,
    output logic                                                  o_full
);

    localparam int L_W     = $clog2(WINDOW);
    localparam int MAG_W   = lclp_pkg::TARED_W + L_W;
    localparam int AVG_W   = MAG_W + lclp_pkg::FRAC_W + 1;
    localparam int REM_W   = (L_W > 0) ? L_W : 1;
    // Reciprocal for an exact floor(m / WINDOW) over all m < 2^MAG_W
    localparam int K_SH    = MAG_W + L_W;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << K_SH) / WINDOW) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int NSTG    = 4;

    // floor(256 * r / WINDOW) for each remainder r
    logic [lclp_pkg::FRAC_W-1:0] frac_tab [WINDOW];
    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_frac
        assign frac_tab[gi] = lclp_pkg::FRAC_W'((256 * gi) / WINDOW);
    end

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] ld;

    logic                    r_neg3, r_neg4, r_neg5;
    logic                    r_full3, r_full4, r_full5, r_full6;
    logic [MAG_W-1:0]        r_mag3, r_mag4;
    logic [MAG_W-1:0]        r_q4, r_q5;
    logic [REM_W-1:0]        r_rem5;
    logic signed [AVG_W-1:0] r_avg6;

    logic [MAG_W-1:0]                   n_mag3;
    logic [PROD_W-1:0]                  n_prod4;
    logic [REM_W-1:0]                   n_rem5;
    logic [MAG_W+lclp_pkg::FRAC_W-1:0]  avg_mag;
    logic signed [AVG_W-1:0]            n_avg6;

    // Stage loads: a stage takes an item when empty or when it hands its own on
    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_in_ready  = ld[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_avg       = r_avg6;
    assign o_full      = r_full6;

    // Datapath of each stage
    always_comb begin
        n_mag3  = i_sum[MAG_W-1] ? MAG_W'(-i_sum) : MAG_W'(i_sum);
        n_prod4 = PROD_W'(r_mag3) * PROD_W'(RECIP);
        n_rem5  = REM_W'(r_mag4 - MAG_W'(r_q4 * MAG_W'(WINDOW)));
        avg_mag = {r_q5, frac_tab[r_rem5]};
        n_avg6  = r_neg5 ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_neg3  <= i_sum[MAG_W-1];
            r_mag3  <= n_mag3;
            r_full3 <= i_full;
        end
        if (ld[1]) begin
            r_neg4  <= r_neg3;
            r_mag4  <= r_mag3;
            r_q4    <= MAG_W'(n_prod4 >> K_SH);
            r_full4 <= r_full3;
        end
        if (ld[2]) begin
            r_neg5  <= r_neg4;
            r_q5    <= r_q4;
            r_rem5  <= n_rem5;
            r_full5 <= r_full4;
        end
        if (ld[3]) begin
            r_avg6  <= n_avg6;
            r_full6 <= r_full5;
        end
    end

endmodule

`default_nettype wire

/* src/load_cell_average_lowpass_filter.sv */
// Top level: tare, moving-average ring, Q8 exponential smoothing.
`default_nettype none

// Takes one signed 24-bit load-cell sample per cycle unless i_out_ready stalls
// the pipeline, and returns one result per item: tare subtraction and the
// ring/sum update (one stage), the Q8 average by reciprocal multiply over four
// stages, then the smoothing update in the output register. The smoothing
// level's feedback loop (subtract, 10-bit gain multiply, add, saturate) is what
// sets the clock. The ring of WINDOW entries, the running sum and the level are
// cleared by reset; until the ring has filled once, o_filtered_value is the
// held level (zero after reset) and o_window_full is low. Configuration writes
// (index 0 tare, index 1 gain) are taken every cycle and belong in idle time.
module load_cell_average_lowpass_filter #(
    parameter int WINDOW = lclp_pkg::DEFAULT_WINDOW
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // sample channel
    input  wire                                      i_in_valid,
    output logic                                     o_in_ready,
    input  wire signed [lclp_pkg::SAMPLE_W-1:0]      i_raw_sample,
    // result channel
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output logic signed [lclp_pkg::LEVEL_W-1:0]      o_filtered_value,
    output logic                                     o_window_full,
    // configuration channel
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire [lclp_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire [lclp_pkg::CFG_DATA_W-1:0]           i_cfg_data
);

    localparam int L_W     = $clog2(WINDOW);
    localparam int POS_W   = (L_W > 0) ? L_W : 1;
    localparam int SUM_W   = lclp_pkg::TARED_W + L_W;
    localparam int AVG_W   = SUM_W + lclp_pkg::FRAC_W + 1;
    localparam int DIFF_W  = AVG_W + 1;
    localparam int GAIN_SW = lclp_pkg::GAIN_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_SW;
    localparam int LVL_W   = lclp_pkg::LEVEL_W;
    localparam int SAMP_W  = lclp_pkg::SAMPLE_W;
    localparam int TAR_W   = lclp_pkg::TARED_W;

    // Configuration registers
    logic signed [SAMP_W-1:0]          r_tare;
    logic [lclp_pkg::GAIN_W-1:0]       r_gain;

    // Input stage
    logic                              r_s1_vld;
    logic signed [SAMP_W-1:0]          r_s1_raw;

    // Ring stage and its state
    logic                              r_s2_vld;
    logic signed [SUM_W-1:0]           r_s2_sum;
    logic                              r_s2_full;
    logic signed [TAR_W-1:0]           r_ring [WINDOW];
    logic [POS_W-1:0]                  r_pos;
    logic                              r_filled;
    logic signed [SUM_W-1:0]           r_sum;

    // Output stage
    logic                              r_out_vld;
    logic                              r_out_full;
    logic signed [LVL_W-1:0]           r_lp;

    logic                              ld_s1, ld_s2, ld_out;
    logic                              take_s2;
    logic                              div_in_ready, div_out_vld, div_full;
    logic signed [AVG_W-1:0]           div_avg;

    logic signed [TAR_W-1:0]           tared;
    logic signed [SUM_W-1:0]           n_sum;
    logic [POS_W-1:0]                  n_pos;
    logic                              wrap;

    logic signed [DIFF_W-1:0]          diff;
    logic signed [GAIN_SW-1:0]         gain_s;
    logic signed [PROD_W-1:0]          prod;
    logic signed [PROD_W-1:0]          step;
    logic signed [PROD_W-1:0]          n_raw_lp;
    logic signed [PROD_W-1:0]          lvl_max_x, lvl_min_x;
    logic signed [LVL_W-1:0]           n_lp;

    // Handshake chain
    assign ld_out      = !r_out_vld || i_out_ready;
    assign ld_s2       = !r_s2_vld || div_in_ready;
    assign ld_s1       = !r_s1_vld || ld_s2;
    assign take_s2     = ld_s2 && r_s1_vld;
    assign o_in_ready  = ld_s1;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_vld;
    assign o_filtered_value = r_lp;
    assign o_window_full    = r_out_full;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare <= lclp_pkg::TARE_RESET;
            r_gain <= lclp_pkg::GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lclp_pkg::CFG_TARE: r_tare <= $signed(i_cfg_data[SAMP_W-1:0]);
                lclp_pkg::CFG_GAIN: r_gain <= i_cfg_data[lclp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (ld_s1) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s1) begin
            r_s1_raw <= i_raw_sample;
        end
    end

    // Tare, ring replacement and running sum
    always_comb begin
        tared = $signed({r_s1_raw[SAMP_W-1], r_s1_raw}) - $signed({r_tare[SAMP_W-1], r_tare});
        n_sum = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(tared);
        wrap  = (r_pos == POS_W'(WINDOW - 1));
        n_pos = wrap ? '0 : r_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_pos    <= '0;
            r_filled <= 1'b0;
            r_sum    <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (ld_s2) r_s2_vld <= r_s1_vld;
            if (take_s2) begin
                r_ring[r_pos] <= tared;
                r_pos         <= n_pos;
                r_sum         <= n_sum;
                if (wrap) r_filled <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_s2) begin
            r_s2_sum  <= n_sum;
            r_s2_full <= r_filled || wrap;
        end
    end

    // Average pipeline
    lclp_avg_div #(
        .WINDOW (WINDOW)
    ) u_avg_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_s2_vld),
        .o_in_ready  (div_in_ready),
        .i_sum       (r_s2_sum),
        .i_full      (r_s2_full),
        .o_out_valid (div_out_vld),
        .i_out_ready (ld_out),
        .o_avg       (div_avg),
        .o_full      (div_full)
    );

    // Smoothing update: lp + floor(gain * (avg - lp) / 256), saturated
    always_comb begin
        diff      = DIFF_W'(div_avg) - DIFF_W'(r_lp);
        gain_s    = $signed({1'b0, r_gain});
        prod      = PROD_W'(gain_s) * PROD_W'(diff);
        step      = prod >>> lclp_pkg::FRAC_W;
        n_raw_lp  = PROD_W'(r_lp) + step;
        lvl_max_x = {{(PROD_W-LVL_W){lclp_pkg::LEVEL_MAX[LVL_W-1]}}, lclp_pkg::LEVEL_MAX};
        lvl_min_x = {{(PROD_W-LVL_W){lclp_pkg::LEVEL_MIN[LVL_W-1]}}, lclp_pkg::LEVEL_MIN};
        if (n_raw_lp > lvl_max_x) begin
            n_lp = lclp_pkg::LEVEL_MAX;
        end else if (n_raw_lp < lvl_min_x) begin
            n_lp = lclp_pkg::LEVEL_MIN;
        end else begin
            n_lp = n_raw_lp[LVL_W-1:0];
        end
    end

    // Output register, which also holds the smoothed level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_full <= 1'b0;
            r_lp       <= '0;
        end else if (ld_out) begin
            r_out_vld <= div_out_vld;
            if (div_out_vld) begin
                r_out_full <= div_full;
                if (div_full) r_lp <= n_lp;
            end
        end
    end

    // Checks
    a_filled_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |=> r_filled)
        else $error("ring fill flag dropped");

    a_level_zero_before_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_filled |-> (r_lp == '0))
        else $error("level moved before the ring filled");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(WINDOW - 1))
        else $error("ring position out of range");

    a_out_full_implies_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_full |-> r_filled)
        else $error("result flagged full ahead of the ring");

    a_level_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ld_out && div_out_vld) |=> $stable(r_lp))
        else $error("level changed without an item");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the load-cell tare, moving-average and Q8 smoothing filter.
`timescale 1ns / 100ps

module tb;

    localparam int WINDOW     = lclp_pkg::DEFAULT_WINDOW;
    localparam int SAMPLE_W   = lclp_pkg::SAMPLE_W;
    localparam int LEVEL_W    = lclp_pkg::LEVEL_W;
    localparam int GAIN_W     = lclp_pkg::GAIN_W;
    localparam int CFG_DATA_W = lclp_pkg::CFG_DATA_W;
    localparam int IDLE_PCT   = 28;
    localparam int HOLD_AT    = 350;
    localparam int HOLD_LEN   = 150;
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      full;
    } t_reading;

    // DUT connections
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_raw_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [LEVEL_W-1:0]  o_filtered_value;
    logic                       o_window_full;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    lclp_pkg::t_cfg_idx         i_cfg_index = lclp_pkg::CFG_TARE;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // Samples waiting to be offered, and readings still owed by the block
    logic signed [SAMPLE_W-1:0] sample_q[$];
    t_reading                   reading_q[$];

    // Filter model state
    logic signed [SAMPLE_W-1:0] tare_reg = lclp_pkg::TARE_RESET;
    logic [GAIN_W-1:0]          gain_reg = lclp_pkg::GAIN_RESET;
    longint                     ring_mem[WINDOW];
    int                         wr_pos = 0;
    logic                       filled = 1'b0;
    longint                     sum_acc = 0;
    longint                     level_q8 = 0;

    int  err_cnt = 0;
    int  result_cnt = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  idle_en = 1'b1;

    load_cell_average_lowpass_filter #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_raw_sample    (i_raw_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_filtered_value(o_filtered_value),
        .o_window_full   (o_window_full),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Tare the sample, update ring and sum, smooth the average once the ring has filled, queue the reading
    task automatic advance_filter(input logic signed [SAMPLE_W-1:0] raw);
        longint   tared;
        longint   avg;
        longint   next_lvl;
        t_reading r;
        tared = longint'(raw) - longint'(tare_reg);
        sum_acc = sum_acc - ring_mem[wr_pos] + tared;
        ring_mem[wr_pos] = tared;
        if (wr_pos == WINDOW - 1) begin
            wr_pos = 0;
            filled = 1'b1;
        end else begin
            wr_pos++;
        end
        if (filled) begin
            avg = (sum_acc * 256) / WINDOW;
            next_lvl = level_q8 + ((longint'(gain_reg) * (avg - level_q8)) >>> 8);
            if (next_lvl > longint'(lclp_pkg::LEVEL_MAX))
                next_lvl = longint'(lclp_pkg::LEVEL_MAX);
            if (next_lvl < longint'(lclp_pkg::LEVEL_MIN))
                next_lvl = longint'(lclp_pkg::LEVEL_MIN);
            level_q8 = next_lvl;
        end
        r.level = level_q8[LEVEL_W-1:0];
        r.full  = filled;
        reading_q.push_back(r);
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                advance_filter(i_raw_sample);
            if (!i_in_valid || o_in_ready) begin
                if (sample_q.size() > 0 &&
                    !(idle_en && $urandom_range(0, 99) < IDLE_PCT)) begin
                    i_in_valid   <= 1'b1;
                    i_raw_sample <= sample_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor, with one long hold-off to back the pipeline up
    always @(posedge i_clk) begin
        t_reading r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                result_cnt++;
                if (reading_q.size() == 0) begin
                    $error("unexpected item: filtered_value %0d window_full %0b",
                           o_filtered_value, o_window_full);
                    err_cnt++;
                end else begin
                    r = reading_q.pop_front();
                    if (o_filtered_value !== r.level) begin
                        $error("filtered_value: expected %0d, actual %0d",
                               r.level, o_filtered_value);
                        err_cnt++;
                    end
                    if (o_window_full !== r.full) begin
                        $error("window_full: expected %0b, actual %0b",
                               r.full, o_window_full);
                        err_cnt++;
                    end
                end
            end
            if (result_cnt == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Register write; block must be idle
    task automatic write_reg(input lclp_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lclp_pkg::CFG_TARE)
            tare_reg = data;
        else
            gain_reg = data[GAIN_W-1:0];
    endtask

    // Wait until every item has been offered, taken and answered
    task automatic drain;
        while (sample_q.size() != 0 || reading_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input longint centre);
        longint v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? longint'(SMP_MAX) : longint'(SMP_MIN);
            1, 2, 3: v = longint'($signed(SAMPLE_W'($urandom())));
            default: v = centre + longint'($urandom_range(0, 4000)) - 2000;
        endcase
        if (v > longint'(SMP_MAX))
            v = longint'(SMP_MAX);
        if (v < longint'(SMP_MIN))
            v = longint'(SMP_MIN);
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_W'($urandom_range(257, 511));
            2:       return 9'd256;
            default: return GAIN_W'($urandom_range(1, 256));
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [GAIN_W-1:0]          g;
        logic signed [SAMPLE_W-1:0] t;
        longint                     centre;
        for (int i = 0; i < WINDOW; i++)
            ring_mem[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: held zero until the ring fills, extremes of the sample
        @(negedge i_clk);
        sample_q = '{SMP_MAX, SMP_MIN, SAMPLE_W'(0), SAMPLE_W'(-1), SAMPLE_W'(1),
                     SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN};
        drain();

        // Most negative tare with top samples, gain above unity: level saturates high
        write_reg(lclp_pkg::CFG_TARE, SMP_MIN);
        write_reg(lclp_pkg::CFG_GAIN, 24'h1FF);
        @(negedge i_clk);
        repeat (10) sample_q.push_back(SMP_MAX);
        drain();

        // Most positive tare with bottom samples, zero gain: level must not move
        write_reg(lclp_pkg::CFG_TARE, SMP_MAX);
        write_reg(lclp_pkg::CFG_GAIN, 24'hFFFE00);
        @(negedge i_clk);
        repeat (3) sample_q.push_back(SMP_MIN);
        drain();

        // Random phases
        for (int p = 0; p < 8; p++) begin
            case (p)
                5: begin
                    t = SMP_MAX;
                    g = GAIN_W'($urandom_range(384, 511));
                    centre = longint'(SMP_MIN);
                end
                6: begin
                    t = SMP_MIN;
                    g = GAIN_W'($urandom_range(300, 511));
                    centre = longint'(SMP_MAX);
                end
                default: begin
                    t = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom())
                                                    : SAMPLE_W'($urandom_range(0, 200000))
                                                      - SAMPLE_W'(100000);
                    g = pick_gain();
                    centre = longint'($signed(SAMPLE_W'($urandom())));
                end
            endcase
            idle_en = (p != 2);
            write_reg(lclp_pkg::CFG_GAIN, {15'($urandom()), g});
            write_reg(lclp_pkg::CFG_TARE, t);
            @(negedge i_clk);
            for (int i = 0; i < 140; i++)
                sample_q.push_back(pick_sample(centre));
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("load_cell_average_lowpass_filter verification clean");
        else
            $display("load_cell_average_lowpass_filter verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("load_cell_average_lowpass_filter verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/lclp_pkg.sv
src/lclp_avg_div.sv
src/load_cell_average_lowpass_filter.sv
tb/sv/tb.sv
